// ----- rtl/b64e_pkg.sv -----
package b64e_pkg;

    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [6:0] PadChar = 7'h3D;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // one character slot: a 6-bit symbol value or a pad
    typedef struct packed {
        logic       pad;
        logic [5:0] val;
    } t_sym;

    // characters caused by one input byte
    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic            last;
        t_sym [3:0]      syms;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

// ----- rtl/b64e_if.sv -----
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/b64e_front.sv -----
module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    b64e_in_if.sink              i_in,
    input  b64e_pkg::t_q_stat    i_q_stat,
    output b64e_pkg::t_q_wr      o_q_wr
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_carry, n_carry;
    logic             acc;
    b64e_pkg::t_job   job;
    logic [7:0]       b;

    assign i_in.ready = !i_q_stat.full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    always_comb begin
        job      = '0;
        n_phase  = r_phase;
        n_carry  = r_carry;
        job.last = i_in.last_byte;
        unique case (r_phase)
            b64e_pkg::PH_SECOND: begin
                job.syms[0].val = {r_carry[1:0], b[7:4]};
                if (i_in.last_byte) begin
                    job.syms[1].val = {b[3:0], 2'b00};
                    job.syms[2].pad = 1'b1;
                    job.cnt_m1      = 2'd2;
                    n_phase         = b64e_pkg::PH_FIRST;
                    n_carry         = '0;
                end else begin
                    job.cnt_m1 = 2'd0;
                    n_phase    = b64e_pkg::PH_THIRD;
                    n_carry    = b[3:0];
                end
            end
            b64e_pkg::PH_THIRD: begin
                job.syms[0].val = {r_carry, b[7:6]};
                job.syms[1].val = b[5:0];
                job.cnt_m1      = 2'd1;
                n_phase         = b64e_pkg::PH_FIRST;
                n_carry         = '0;
            end
            default: begin
                job.syms[0].val = b[7:2];
                if (i_in.last_byte) begin
                    job.syms[1].val = {b[1:0], 4'b0000};
                    job.syms[2].pad = 1'b1;
                    job.syms[3].pad = 1'b1;
                    job.cnt_m1      = 2'd3;
                    n_phase         = b64e_pkg::PH_FIRST;
                    n_carry         = '0;
                end else begin
                    job.cnt_m1 = 2'd0;
                    n_phase    = b64e_pkg::PH_SECOND;
                    n_carry    = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    assign o_q_wr.push = acc;
    assign o_q_wr.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_FIRST;
            r_carry <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

// ----- rtl/b64e_fifo.sv -----
module b64e_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64e_pkg::t_q_wr    i_wr,
    input  logic               i_pop,
    output b64e_pkg::t_job     o_head,
    output b64e_pkg::t_q_stat  o_stat
);

    localparam logic [b64e_pkg::QPtrW-1:0] PtrLast = b64e_pkg::QPtrW'(b64e_pkg::QDepth - 1);

    b64e_pkg::t_job                r_mem [b64e_pkg::QDepth];
    logic [b64e_pkg::QPtrW-1:0]    r_wptr, r_rptr;
    logic [b64e_pkg::QCntW-1:0]    r_cnt;
    logic                          do_push, do_pop;

    assign o_stat.full  = (r_cnt == b64e_pkg::QCntW'(b64e_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_wr.push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrLast) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrLast) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/b64e_back.sv -----
module b64e_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64e_pkg::t_job     i_head,
    input  b64e_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    b64e_out_if.source         o_out
);

    logic [1:0]    r_idx;
    logic          r_valid, n_valid;
    logic [6:0]    r_char, n_char;
    logic          r_last, n_last;
    logic          load, fin;
    b64e_pkg::t_sym cur;

    assign cur  = i_head.syms[r_idx];
    assign fin  = (r_idx == i_head.cnt_m1);
    assign load = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && fin;

    always_comb begin
        n_char  = cur.pad ? b64e_pkg::PadChar : b64e_pkg::sym_char(cur.val);
        n_last  = i_head.last && fin;
        n_valid = load ? 1'b1 : (o_out.ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            if (load) begin
                r_idx <= fin ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// Base64 stream encoder (standard alphabet, '=' padding). Send raw bytes one
// request at a time, with last_byte high on the final byte of each message;
// every message must hold at least one byte. Characters come out one request
// per cycle while the receiver is ready; last_char marks the final character
// of each encoded message (after any padding). A byte is taken whenever the
// two-entry job queue has room; the output side moves one character per
// cycle while the receiver is ready, so the sustained rate is set by the
// output register: three bytes make four characters, and a final byte of a
// group of one or two makes four or three characters. The first character
// of a byte is registered in the job queue and then in the output register.
// Output stalls only back up the queue; the input keeps flowing until it fills.
module base64_stream_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64e_in_if.sink       i_in,
    b64e_out_if.source    o_out
);

    b64e_pkg::t_q_wr    q_wr;
    b64e_pkg::t_q_stat  q_stat;
    b64e_pkg::t_job     q_head;
    logic               q_pop;

    // Classify each byte by group position and build its character job.
    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_q_wr   (q_wr)
    );

    // Decouple byte intake from character output.
    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Walk each job into the output register, one character per cycle while the output is ready.
    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

`ifndef SYNTH
    // Never write a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_wr.push && q_stat.full))
        else $error("job written into full queue");

    // An accepted byte leaves a job waiting in the next cycle.
    a_job_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !q_stat.empty)
        else $error("accepted byte left no job");

    // Never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("pop from empty queue");
`endif

endmodule
